// ===== hw/rtl/rd_pkg.sv =====
// Shared types and constants for the record deque.
package rd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int NUM_W     = 32;
    localparam int BILL_W    = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_LISTED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_APPEND,
        CELL_ROTATE
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic [NUM_W-1:0]  number;
        logic [BILL_W-1:0] bill;
    } record_t;

    typedef struct packed {
        cell_cmd_t cmd;
        record_t   rec;
    } chain_ctl_t;

endpackage

// ===== hw/rtl/rd_if.sv =====
// Request and response channel interfaces of the record deque.
interface rd_req_if
    import rd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [NUM_W-1:0]  customer_number;
    logic [BILL_W-1:0] bill_amount;

    modport source (output valid, output op, output customer_number, output bill_amount,
                    input ready);
    modport sink   (input valid, input op, input customer_number, input bill_amount,
                    output ready);
endinterface

interface rd_rsp_if
    import rd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [NUM_W-1:0]  out_number;
    logic [BILL_W-1:0] out_bill;
    logic              last;

    modport source (output valid, output status, output out_number, output out_bill,
                    output last, input ready);
    modport sink   (input valid, input status, input out_number, input out_bill,
                    input last, output ready);
endinterface

// ===== hw/rtl/rd_cell.sv =====
// One storage cell of the deque chain.
module rd_cell
    import rd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic [CNT_W-1:0] count,
    input  record_t          left,
    input  record_t          right,
    input  record_t          head,
    output record_t          data
);

    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

    record_t data_reg;
    record_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.cmd)
            CELL_SHIFT_R:
            begin
                data_next = (INDEX == 0) ? ctl.rec : left;
            end
            CELL_SHIFT_L:
            begin
                data_next = right;
            end
            CELL_APPEND:
            begin
                if (count == MY_POS)
                begin
                    data_next = ctl.rec;
                end
            end
            CELL_ROTATE:
            begin
                // the tail cell takes the head back, the rest move toward the front
                data_next = (count == MY_NEXT) ? head : right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/rd_chain.sv =====
// Row of deque cells, front record in cell zero.
module rd_chain
    import rd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic [CNT_W-1:0] count,
    output record_t          head
);

    record_t cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        record_t left_in;
        record_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = ctl.rec;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        rd_cell #(
            .DEPTH (DEPTH),
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count),
            .left  (left_in),
            .right (right_in),
            .head  (cell_data[0]),
            .data  (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

// ===== hw/rtl/record_deque.sv =====
// Top level of the record deque: control, entry count and response register.
//
//   channel   dir   payload
//   req       in    op, customer_number, bill_amount
//   rsp       out   status, out_number, out_bill, last
//
// Push, pop and unused ops each give one response.
// A dump lists every stored record by rotation of the cell chain and blocks new requests
// until its last record is loaded into the response register.
// A new request is taken only when the response register is empty or draining.
// rsp stalls hold the chain and the dump counter.
// Reset clears the entry count and the state; cell contents are left as is.
module record_deque
    import rd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    rd_req_if.sink   req,
    rd_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;

    logic              rsp_valid_reg, rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    record_t           rsp_rec_reg, rsp_rec_next;
    logic              rsp_last_reg, rsp_last_next;

    logic              out_free;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    op_t               op;
    chain_ctl_t        ctl;
    record_t           head;

    assign op       = op_t'(req.op);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = req.valid && req.ready;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    rd_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .count (count_reg),
        .head  (head)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_DUMP && !is_empty)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (out_free && remain_reg == ONE_CNT)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and response
    always_comb
    begin
        ctl.cmd         = CELL_HOLD;
        ctl.rec.number  = req.customer_number;
        ctl.rec.bill    = req.bill_amount;
        count_next      = count_reg;
        remain_next     = remain_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_rec_next    = rsp_rec_reg;
        rsp_last_next   = rsp_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STAT_DONE;
                    rsp_rec_next    = '0;
                    rsp_last_next   = 1'b1;
                    case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                rsp_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.cmd    = (op == OP_PUSH_FRONT) ? CELL_SHIFT_R : CELL_APPEND;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                rsp_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ctl.cmd    = (op == OP_POP_FRONT) ? CELL_SHIFT_L : CELL_HOLD;
                                count_next = count_reg - ONE_CNT;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // listing starts in ST_DUMP once the response register is free
                                rsp_valid_next = rsp_valid_reg && !rsp.ready;
                                remain_next    = count_reg;
                            end
                        end
                        default:
                        begin
                            rsp_status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    ctl.cmd         = CELL_ROTATE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STAT_LISTED;
                    rsp_rec_next    = head;
                    rsp_last_next   = (remain_reg == ONE_CNT);
                    remain_next     = remain_reg - ONE_CNT;
                end
            end
            default:
            begin
                ctl.cmd = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_rec_reg    <= rsp_rec_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.out_number = rsp_rec_reg.number;
    assign rsp.out_bill   = rsp_rec_reg.bill;
    assign rsp.last       = rsp_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> (remain_reg != '0 && count_reg != '0))
        else $error("dump running with nothing to list");

    a_full_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
        |=> (count_reg == $past(count_reg) && rsp_status_reg == STAT_FULL))
        else $error("push on full queue changed the count");

    a_dump_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> count_reg == $past(count_reg))
        else $error("count moved during dump");
`endif

endmodule
